>>> src/clwc_pkg.sv
// Package for the circular list with cursor: action and status codes,
// field widths and the result struct shared by the control and top level.
// No dependencies.
`default_nettype none

package clwc_pkg;

    localparam int DEFAULT_NODE_DEPTH = 256;
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [ACTION_W-1:0] ACT_ADD_HEAD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_TAIL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FIRST    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_NEXT     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOCUR = 2'd3;

    typedef struct packed {
        logic                       valid;
        logic [STATUS_W-1:0]        status;
        logic signed [VALUE_W-1:0]  data;
        logic [COUNT_W-1:0]         count;
    } resp_t;

endpackage

`default_nettype wire

>>> src/clwc_ram.sv
// Simple dual-port synchronous RAM, one write and one read port,
// registered read data, read-before-write on a same-address collision.
// Depends on clwc_pkg for default sizes.
`default_nettype none

module clwc_ram #(
    parameter int DEPTH = clwc_pkg::DEFAULT_NODE_DEPTH,
    parameter int WIDTH = clwc_pkg::VALUE_W
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> src/clwc_ctrl.sv
// Sequencer for the circular list: pointer registers, free chain,
// node memory address/write control and the result of each transaction.
// Depends on clwc_pkg; drives two clwc_ram instances in the top level.
`default_nettype none

module clwc_ctrl #(
    parameter int NODE_DEPTH = clwc_pkg::DEFAULT_NODE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [clwc_pkg::ACTION_W-1:0]         action,
    input  logic signed [clwc_pkg::VALUE_W-1:0]   value,
    output logic                                  busy,
    output logic [$clog2(NODE_DEPTH)-1:0]         link_raddr,
    input  logic [$clog2(NODE_DEPTH)-1:0]         link_rdata,
    output logic                                  link_we,
    output logic [$clog2(NODE_DEPTH)-1:0]         link_waddr,
    output logic [$clog2(NODE_DEPTH)-1:0]         link_wdata,
    output logic [$clog2(NODE_DEPTH)-1:0]         val_raddr,
    input  logic [clwc_pkg::VALUE_W-1:0]          val_rdata,
    output logic                                  val_we,
    output logic [$clog2(NODE_DEPTH)-1:0]         val_waddr,
    output logic [clwc_pkg::VALUE_W-1:0]          val_wdata,
    output clwc_pkg::resp_t                       resp
);

    import clwc_pkg::*;

    localparam int AW = $clog2(NODE_DEPTH);
    localparam int CW = $clog2(NODE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_FIRST = 6'b000100,
        S_NEXT1 = 6'b001000,
        S_NEXT2 = 6'b010000,
        S_REM   = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;      // link[tail], the first element
    logic [AW-1:0]   tail_reg, tail_next;
    logic [AW-1:0]   cursor_reg, cursor_next;
    logic [AW-1:0]   before_reg, before_next;
    logic [AW-1:0]   free_head_reg, free_head_next;
    logic [CW-1:0]   free_len_reg, free_len_next;
    logic [CW-1:0]   mark_reg, mark_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            cvalid_reg, cvalid_next;
    logic [AW-1:0]   new_idx_reg, new_idx_next;
    logic            at_tail_reg, at_tail_next;
    logic            from_free_reg, from_free_next;

    logic            empty;
    logic            full;
    logic [AW-1:0]   alloc_idx;

    assign empty     = (count_reg == '0);
    assign full      = (free_len_reg == '0) && (mark_reg == CW'(NODE_DEPTH));
    assign alloc_idx = (free_len_reg != '0) ? free_head_reg : mark_reg[AW-1:0];
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cursor_next    = cursor_reg;
        before_next    = before_reg;
        free_head_next = free_head_reg;
        free_len_next  = free_len_reg;
        mark_next      = mark_reg;
        count_next     = count_reg;
        cvalid_next    = cvalid_reg;
        new_idx_next   = new_idx_reg;
        at_tail_next   = at_tail_reg;
        from_free_next = from_free_reg;

        link_raddr = cursor_reg;
        link_we    = 1'b0;
        link_waddr = alloc_idx;
        link_wdata = head_reg;
        val_raddr  = cursor_reg;
        val_we     = 1'b0;
        val_waddr  = alloc_idx;
        val_wdata  = value;

        resp.valid  = 1'b0;
        resp.status = ST_OK;
        resp.data   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (action) inside
                        ACT_ADD_HEAD, ACT_ADD_TAIL:
                        begin
                            if (full)
                            begin
                                resp.valid  = 1'b1;
                                resp.status = ST_FULL;
                            end
                            else
                            begin
                                // store value and successor; fetch next free node
                                val_we         = 1'b1;
                                link_we        = 1'b1;
                                link_wdata     = empty ? alloc_idx : head_reg;
                                link_raddr     = free_head_reg;
                                new_idx_next   = alloc_idx;
                                at_tail_next   = (action == ACT_ADD_TAIL);
                                from_free_next = (free_len_reg != '0);
                                state_next     = S_ADD;
                            end
                        end
                        ACT_FIRST:
                        begin
                            if (empty)
                            begin
                                resp.valid  = 1'b1;
                                resp.status = ST_EMPTY;
                            end
                            else
                            begin
                                val_raddr  = head_reg;
                                state_next = S_FIRST;
                            end
                        end
                        ACT_NEXT:
                        begin
                            if (empty)
                            begin
                                resp.valid  = 1'b1;
                                resp.status = ST_EMPTY;
                            end
                            else
                            begin
                                link_raddr = cursor_reg;
                                state_next = S_NEXT1;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (empty)
                            begin
                                resp.valid  = 1'b1;
                                resp.status = ST_EMPTY;
                            end
                            else if (!cvalid_reg)
                            begin
                                resp.valid  = 1'b1;
                                resp.status = ST_NOCUR;
                            end
                            else
                            begin
                                // read old successor while pushing node on free chain
                                link_raddr = cursor_reg;
                                val_raddr  = cursor_reg;
                                link_we    = 1'b1;
                                link_waddr = cursor_reg;
                                link_wdata = free_head_reg;
                                state_next = S_REM;
                            end
                        end
                        default:
                        begin
                            resp.valid = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (from_free_reg)
                begin
                    free_head_next = link_rdata;
                    free_len_next  = free_len_reg - CW'(1);
                end
                else
                begin
                    mark_next = mark_reg + CW'(1);
                end
                if (empty)
                begin
                    head_next   = new_idx_reg;
                    tail_next   = new_idx_reg;
                    cursor_next = new_idx_reg;
                    before_next = new_idx_reg;
                    cvalid_next = 1'b0;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg;
                    link_wdata = new_idx_reg;
                    if (before_reg == tail_reg)
                    begin
                        before_next = new_idx_reg;
                    end
                    if (at_tail_reg)
                    begin
                        tail_next = new_idx_reg;
                    end
                    else
                    begin
                        head_next = new_idx_reg;
                    end
                end
                count_next = count_reg + CW'(1);
                resp.valid = 1'b1;
                state_next = S_IDLE;
            end
            S_FIRST:
            begin
                before_next = tail_reg;
                cursor_next = head_reg;
                cvalid_next = 1'b1;
                resp.valid  = 1'b1;
                resp.data   = val_rdata;
                state_next  = S_IDLE;
            end
            S_NEXT1:
            begin
                before_next = cursor_reg;
                cursor_next = link_rdata;
                cvalid_next = 1'b1;
                val_raddr   = link_rdata;
                state_next  = S_NEXT2;
            end
            S_NEXT2:
            begin
                resp.valid = 1'b1;
                resp.data  = val_rdata;
                state_next = S_IDLE;
            end
            S_REM:
            begin
                // a lone node is its own predecessor: its link already holds the free chain
                if (cursor_reg != before_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = before_reg;
                    link_wdata = link_rdata;
                end
                if ((cursor_reg == tail_reg) && (count_reg > CW'(1)))
                begin
                    tail_next = before_reg;
                end
                if (cursor_reg == head_reg)
                begin
                    head_next = link_rdata;
                end
                cursor_next    = before_reg;
                cvalid_next    = 1'b0;
                free_head_next = cursor_reg;
                free_len_next  = free_len_reg + CW'(1);
                count_next     = count_reg - CW'(1);
                resp.valid     = 1'b1;
                resp.data      = val_rdata;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // low bits of the count after this transaction
        resp.count = COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cursor_reg    <= '0;
            before_reg    <= '0;
            free_head_reg <= '0;
            free_len_reg  <= '0;
            mark_reg      <= '0;
            count_reg     <= '0;
            cvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cursor_reg    <= cursor_next;
            before_reg    <= before_next;
            free_head_reg <= free_head_next;
            free_len_reg  <= free_len_next;
            mark_reg      <= mark_next;
            count_reg     <= count_next;
            cvalid_reg    <= cvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_idx_reg   <= new_idx_next;
        at_tail_reg   <= at_tail_next;
        from_free_reg <= from_free_next;
    end

endmodule

`default_nettype wire

>>> src/circular_list_with_cursor.sv
// Top level of the circular list with cursor: node value and link memories,
// the sequencer and the result register.
// Depends on clwc_pkg, clwc_ram and clwc_ctrl.
//
// Usage:
//   Command channel: a transaction (action, value) is accepted on a rising
//   edge where start is high and busy is low. busy stays high while the
//   sequencer works through the node memories.
//   Result channel: done is high for exactly one cycle with status, data and
//   count valid in that cycle. The receiver cannot stall; results are never
//   held back or repeated.
//   Steps per transaction, from acceptance to done:
//     add at head / add at tail: write node, then patch the tail's link unless the list was empty
//     cursor to first: one value memory read
//     advance cursor: link read, then dependent value read
//     remove at cursor: link and value read, then patch predecessor
//     empty, full, no-cursor errors and unused codes: answered from the idle state
//   The single read port per memory, with registered read data, sets these
//   steps. A new transaction can be accepted in the cycle done is high.
//   Reset (rst_n low, asynchronous) empties the list and clears the cursor;
//   node memory contents are not cleared and need no clearing pass, since a
//   node is always written before it is linked in.
`default_nettype none

module circular_list_with_cursor #(
    parameter int NODE_DEPTH = clwc_pkg::DEFAULT_NODE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [clwc_pkg::ACTION_W-1:0]        action,
    input  logic signed [clwc_pkg::VALUE_W-1:0]  value,
    output logic                                 done,
    output logic [clwc_pkg::STATUS_W-1:0]        status,
    output logic signed [clwc_pkg::VALUE_W-1:0]  data,
    output logic [clwc_pkg::COUNT_W-1:0]         count
);

    import clwc_pkg::*;

    localparam int AW = $clog2(NODE_DEPTH);

    // link memory: successor index of each node (also chains free nodes)
    logic [AW-1:0]        link_raddr;
    logic [AW-1:0]        link_rdata;
    logic                 link_we;
    logic [AW-1:0]        link_waddr;
    logic [AW-1:0]        link_wdata;

    // value memory: element payload of each node
    logic [AW-1:0]        val_raddr;
    logic [VALUE_W-1:0]   val_rdata;
    logic                 val_we;
    logic [AW-1:0]        val_waddr;
    logic [VALUE_W-1:0]   val_wdata;

    resp_t                resp;

    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [VALUE_W-1:0]   data_reg;
    logic [COUNT_W-1:0]   count_reg;

    clwc_ram #(
        .DEPTH (NODE_DEPTH),
        .WIDTH (AW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    clwc_ram #(
        .DEPTH (NODE_DEPTH),
        .WIDTH (VALUE_W)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    clwc_ctrl #(
        .NODE_DEPTH (NODE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .value      (value),
        .busy       (busy),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .val_raddr  (val_raddr),
        .val_rdata  (val_rdata),
        .val_we     (val_we),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .resp       (resp)
    );

    // result register: one-cycle strobe, payload captured alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= resp.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp.valid)
        begin
            status_reg <= resp.status;
            data_reg   <= resp.data;
            count_reg  <= resp.count;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign count  = count_reg;

endmodule

`default_nettype wire

>>> src/clwc_checker.sv
// Port-level checker for circular_list_with_cursor, bound to the top level.
// Depends on clwc_pkg.
`default_nettype none

module clwc_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 done,
    input  logic [clwc_pkg::STATUS_W-1:0]        status,
    input  logic signed [clwc_pkg::VALUE_W-1:0]  data,
    input  logic [clwc_pkg::COUNT_W-1:0]         count
);

    import clwc_pkg::*;

    // an accepted transaction either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted transaction neither answered nor busy");

    // a result only follows an acceptance or a busy cycle
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start && !busy)))
        else $error("result without a transaction");

    // the result is shown when the sequencer has finished
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    // empty status reports an empty list
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (count == '0))
        else $error("empty status with nonzero count");

    // no-cursor status only arises on a nonempty list
    a_nocur_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NOCUR)) |-> (count != '0))
        else $error("no-cursor status on empty list");

endmodule

bind circular_list_with_cursor clwc_checker u_clwc_checker (.*);

`default_nettype wire
